// ----- sv/delimited_command_frame_receiver_unit_macros.svh -----
// Assertion macros used by the frame receiver datapath.
`ifndef DELIMITED_COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH
`define DELIMITED_COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define DCFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define DCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dcfr_pkg.sv -----
// Package: types, constants and byte helpers for the frame receiver.
package dcfr_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int FILL_W      = $clog2(FRAME_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'd58;
  localparam logic [BYTE_W-1:0] END_RST    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
  localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z   = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DIG_0   = 8'd48;
  localparam logic [BYTE_W-1:0] CH_DIG_9   = 8'd57;
  localparam logic [BYTE_W-1:0] CH_UP_A    = 8'd65;
  localparam logic [BYTE_W-1:0] CH_UP_Z    = 8'd90;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'd43;
  localparam logic [BYTE_W-1:0] CH_DOT     = 8'd46;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_AUTO  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_FETCH,
    ST_SEND,
    ST_DROP
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic load_byte;
    logic load_drop;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic emit_req;
    logic drop_req;
    logic out_free;
    logic last;
  } sts_t;

  function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

  function automatic logic is_storable(input logic [BYTE_W-1:0] c);
    return (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_PLUS && c <= CH_DOT);
  endfunction

endpackage

// ----- sv/dcfr_ctrl.sv -----
// Controller: sequences receive, frame read-out and dropped report.
module dcfr_ctrl
  import dcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic rx_valid,
  output logic rx_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: begin
        if (rx_valid) begin
          if (sts.drop_req) begin
            state_next = ST_DROP;
          end else if (sts.emit_req) begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_next = ST_SEND;
      ST_SEND: begin
        if (sts.out_free) begin
          state_next = sts.last ? ST_RECV : ST_FETCH;
        end
      end
      ST_DROP: begin
        if (sts.out_free) begin
          state_next = ST_RECV;
        end
      end
      default: state_next = ST_RECV;
    endcase
  end

  always_comb begin
    cmd      = '0;
    rx_stall = 1'b1;
    unique case (state)
      ST_RECV: begin
        rx_stall   = 1'b0;
        cmd.accept = rx_valid;
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_SEND: begin
        cmd.load_byte = sts.out_free;
        cmd.advance   = sts.out_free && !sts.last;
      end
      ST_DROP: cmd.load_drop = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- sv/dcfr_dpath.sv -----
// Datapath: config registers, frame flags, frame store and output register.
`include "delimited_command_frame_receiver_unit_macros.svh"
module dcfr_dpath
  import dcfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 frame_stall,
  output logic                 frame_valid,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic [IDX_W-1:0]     byte_index,
  output logic                 last_byte,
  output logic                 frame_dropped,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;
  logic              auto_open;

  logic              frame_open, frame_open_next;
  logic              in_comment, in_comment_next;
  logic              too_long, too_long_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;

  logic [BYTE_W-1:0] frame_store [FRAME_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] rd_idx;
  logic [BYTE_W-1:0] rd_data;

  logic [BYTE_W-1:0] c;
  logic              open_now;
  logic              open_eff;
  logic              is_end;
  logic [FILL_W-1:0] fill_eff;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RST;
      end_byte   <= END_RST;
      auto_open  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START: start_byte <= cfg_data;
        CFG_END:   end_byte   <= cfg_data;
        CFG_AUTO:  auto_open  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // byte classification
  always_comb begin
    c        = fold_upper(rx_byte);
    open_now = (auto_open && !frame_open) || (c == start_byte);
    open_eff = open_now || frame_open;
    is_end   = (c == end_byte);
    fill_eff = open_now ? '0 : fill_count;
  end

  always_comb begin
    frame_open_next = frame_open;
    in_comment_next = in_comment;
    too_long_next   = too_long;
    fill_count_next = fill_count;
    mem_we          = 1'b0;
    if (cmd.accept && open_eff) begin
      fill_count_next = fill_eff;
      if (is_end) begin
        frame_open_next = 1'b0;
        in_comment_next = 1'b0;
        too_long_next   = 1'b0;
      end else begin
        frame_open_next = 1'b1;
        priority if (c == CH_HASH || c == CH_LPAREN || in_comment) begin
          in_comment_next = 1'b1;
        end else if (c == start_byte) begin
          // start byte is not stored
        end else if (is_storable(c)) begin
          if (fill_eff < FILL_W'(FRAME_DEPTH)) begin
            mem_we          = 1'b1;
            fill_count_next = fill_eff + FILL_W'(1);
          end
          if (fill_eff >= FILL_W'(FRAME_DEPTH - 1)) begin
            too_long_next = 1'b1;
          end
        end else begin
          // ignored byte
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      in_comment <= 1'b0;
      too_long   <= 1'b0;
      fill_count <= '0;
    end else begin
      frame_open <= frame_open_next;
      in_comment <= in_comment_next;
      too_long   <= too_long_next;
      fill_count <= fill_count_next;
    end
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[fill_eff[ADDR_W-1:0]] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data <= frame_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.accept) begin
      rd_idx <= '0;
    end else if (cmd.advance) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (cmd.load_byte || cmd.load_drop) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      frame_byte    <= rd_data;
      byte_index    <= IDX_W'(rd_idx);
      last_byte     <= sts.last;
      frame_dropped <= 1'b0;
    end else if (cmd.load_drop) begin
      frame_byte    <= '0;
      byte_index    <= '0;
      last_byte     <= 1'b1;
      frame_dropped <= 1'b1;
    end
  end

  always_comb begin
    sts.drop_req = open_eff && is_end && too_long;
    sts.emit_req = open_eff && is_end && !too_long && (fill_eff != '0);
    sts.out_free = !frame_valid || !frame_stall;
    sts.last     = (FILL_W'(rd_idx) + FILL_W'(1)) == fill_count;
  end

  `DCFR_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= FILL_W'(FRAME_DEPTH), "fill count past depth")
  `DCFR_ASSERT_NOW(a_open_room, frame_open && !too_long, fill_count < FILL_W'(FRAME_DEPTH), "full frame not flagged too long")
  `DCFR_ASSERT_NOW(a_comment_open, in_comment, frame_open, "comment flag outside a frame")
  `DCFR_ASSERT_NEXT(a_load_valid, cmd.load_byte || cmd.load_drop, frame_valid, "loaded result not presented")

endmodule

// ----- sv/delimited_command_frame_receiver_unit.sv -----
// Top level: delimited command frame receiver (controller plus datapath).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------------
//  rx       | rx_valid / rx_stall       | rx_byte
//  frame    | frame_valid / frame_stall | frame_byte, byte_index, last_byte, frame_dropped
//  cfg      | cfg_we                    | cfg_index, cfg_data
//
// rx_stall stays low between frames.
// On an end byte that closes a non-empty frame that is not too long, the input is
// stalled while the frame is read out of the frame store, each byte by a
// registered read, then an output load that waits for a free output register.
// A dropped-frame report is loaded once the output register is free.
// Reset (rst, synchronous, active high) clears flags, fill count, controller
// and output valid; the frame store needs no clearing.
// The output register lets the next byte be accepted while a result waits.
module delimited_command_frame_receiver_unit
  import dcfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 frame_valid,
  input  logic                 frame_stall,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic [IDX_W-1:0]     byte_index,
  output logic                 last_byte,
  output logic                 frame_dropped
);

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  dcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // flags, fill count, frame store and output register live here
  dcfr_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .frame_stall   (frame_stall),
    .frame_valid   (frame_valid),
    .frame_byte    (frame_byte),
    .byte_index    (byte_index),
    .last_byte     (last_byte),
    .frame_dropped (frame_dropped),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
